/* rtl/core/csms_pkg.sv */
// ----------------------------------------------------------------------------
// csms_pkg
// Shared constants, codes and types of the centre-out spiral scan unit.
// ----------------------------------------------------------------------------
package csms_pkg;

   localparam int MAX_SIDE   = 32;
   localparam int DATA_WIDTH = 16;
   localparam int COORD_W    = $clog2(MAX_SIDE);
   localparam int ADDR_W     = 2 * COORD_W;
   localparam int MEM_DEPTH  = MAX_SIDE * MAX_SIDE;
   localparam int COUNT_W    = 2 * COORD_W;
   localparam int HEAD_W     = 2;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EMIT = 1'b1;

   localparam logic [HEAD_W-1:0] HEAD_LEFT  = 2'd0;
   localparam logic [HEAD_W-1:0] HEAD_UP    = 2'd1;
   localparam logic [HEAD_W-1:0] HEAD_RIGHT = 2'd2;
   localparam logic [HEAD_W-1:0] HEAD_DOWN  = 2'd3;

   localparam logic REG_SIDE_LENGTH     = 1'b0;
   localparam logic REG_START_DIRECTION = 1'b1;

   typedef struct packed {
      logic mem_write;
      logic emit;
      logic out_load;
   } cmd_type;

endpackage

/* rtl/core/csms_req_if.sv */
// ----------------------------------------------------------------------------
// csms_req_if
// Request channel: load or emit transaction with valid/ready handshake.
// ----------------------------------------------------------------------------
interface csms_req_if;
   import csms_pkg::*;

   logic                         valid;
   logic                         ready;
   logic                         operation;
   logic [COORD_W-1:0]           row;
   logic [COORD_W-1:0]           col;
   logic signed [DATA_WIDTH-1:0] value;

   modport source (output valid, operation, row, col, value, input ready);
   modport sink   (input valid, operation, row, col, value, output ready);
endinterface

/* rtl/core/csms_rsp_if.sv */
// ----------------------------------------------------------------------------
// csms_rsp_if
// Response channel: one element per emit transaction, valid/ready handshake.
// ----------------------------------------------------------------------------
interface csms_rsp_if;
   import csms_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] data_out;
   logic                         last;
   logic                         error;

   modport source (output valid, data_out, last, error, input ready);
   modport sink   (input valid, data_out, last, error, output ready);
endinterface

/* rtl/core/center_out_spiral_matrix_scan_unit.sv */
// ----------------------------------------------------------------------------
// center_out_spiral_matrix_scan_unit
// Stores a square matrix and reads it out in a clockwise spiral from the
// centre cell.
// ----------------------------------------------------------------------------
// A load transaction writes one element and gives no response. An emit
// transaction gives one response, the next element of the spiral; it occupies
// the unit through the cursor update with the store read, then the transfer of
// the registered read data into the response register, which waits until that
// register is free; no new transaction is taken before that transfer, as set
// by the registered read port of the element store. A finished response may
// wait in its register while the next transaction is taken. The store has no
// reset: reading a cell that was never loaded gives an undefined value. An
// even side length gives data 0 with error set and leaves the cursor where it
// was. The response that completes side_length squared elements carries last,
// and the next emit restarts at the centre. Registers (32-bit, byte address
// 4*i): 0 side_length, 1 start_direction (0 left, 1 up, 2 right, 3 down).
// ----------------------------------------------------------------------------
module center_out_spiral_matrix_scan_unit (
   input  logic                              clock,
   input  logic                              reset,
   csms_req_if.sink                          req_chan,
   csms_rsp_if.source                        rsp_chan,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [csms_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [csms_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [csms_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);
   import csms_pkg::*;

   logic [COORD_W-1:0] side_ff;
   logic [HEAD_W-1:0]  start_ff;
   logic               csr_write;
   logic               reg_sel;
   cmd_type            cmd;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign reg_sel   = paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff  <= COORD_W'(1);
         start_ff <= HEAD_LEFT;
      end else if (csr_write) begin
         if (reg_sel == REG_SIDE_LENGTH) begin
            side_ff <= pwdata[COORD_W-1:0];
         end else begin
            start_ff <= pwdata[HEAD_W-1:0];
         end
      end
   end

   always_comb begin
      if (reg_sel == REG_SIDE_LENGTH) begin
         prdata = CSR_DATA_W'(side_ff);
      end else begin
         prdata = CSR_DATA_W'(start_ff);
      end
   end

   csms_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_operation (req_chan.operation),
      .req_ready     (req_chan.ready),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .cmd           (cmd)
   );

   csms_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .side_length     (side_ff),
      .start_direction (start_ff),
      .req_row         (req_chan.row),
      .req_col         (req_chan.col),
      .req_value       (req_chan.value),
      .data_out        (rsp_chan.data_out),
      .last            (rsp_chan.last),
      .error           (rsp_chan.error)
   );
endmodule

/* rtl/core/csms_ctrl.sv */
// ----------------------------------------------------------------------------
// csms_ctrl
// Transaction controller: accepts requests, sequences the memory read and
// owns the response valid flag.
// ----------------------------------------------------------------------------
module csms_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_operation,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output csms_pkg::cmd_type cmd
);
   import csms_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_READ = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.mem_write = accept && (req_operation == OP_LOAD);
      cmd.emit      = accept && (req_operation == OP_EMIT);
      cmd.out_load  = (state_ff == S_READ) && out_free;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd.emit) state_in = S_READ;
         end
         S_READ: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef ASSERT_OFF
   a_emit_to_read: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> state_ff == S_READ)
      else $error("emit did not start a read");
   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff)
      else $error("output load lost");
   a_no_accept_in_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ |-> !req_ready)
      else $error("request taken during read");
`endif
endmodule

/* rtl/core/csms_dpath.sv */
// ----------------------------------------------------------------------------
// csms_dpath
// Datapath: element store, spiral cursor and leg counters, output register.
// ----------------------------------------------------------------------------
module csms_dpath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  csms_pkg::cmd_type                      cmd,
   input  logic [csms_pkg::COORD_W-1:0]           side_length,
   input  logic [csms_pkg::HEAD_W-1:0]            start_direction,
   input  logic [csms_pkg::COORD_W-1:0]           req_row,
   input  logic [csms_pkg::COORD_W-1:0]           req_col,
   input  logic signed [csms_pkg::DATA_WIDTH-1:0] req_value,
   output logic signed [csms_pkg::DATA_WIDTH-1:0] data_out,
   output logic                                   last,
   output logic                                   error
);
   import csms_pkg::*;

   logic [DATA_WIDTH-1:0] mem [MEM_DEPTH];
   logic [DATA_WIDTH-1:0] rdata_ff;

   logic [COORD_W-1:0] row_ff, row_in, col_ff, col_in;
   logic [COORD_W-1:0] len_ff, len_in, step_ff, step_in, step_next;
   logic               idx_ff, idx_in;
   logic [HEAD_W-1:0]  heading_ff, heading_in;
   logic [COUNT_W-1:0] count_ff, count_in, count_inc, total;
   logic               is_last;
   logic               odd;
   logic [ADDR_W-1:0]  rd_addr;

   logic               last_ff, err_ff;
   logic [DATA_WIDTH-1:0] dout_ff;
   logic               last_out_ff, err_out_ff;

   assign odd       = side_length[0];
   assign total     = COUNT_W'(side_length) * COUNT_W'(side_length);
   assign count_inc = count_ff + COUNT_W'(1);
   assign is_last   = (count_inc >= total) || (count_inc == '0);
   assign step_next = step_ff + COORD_W'(1);

   always_comb begin
      row_in     = row_ff;
      col_in     = col_ff;
      len_in     = len_ff;
      step_in    = step_ff;
      idx_in     = idx_ff;
      heading_in = heading_ff;
      count_in   = count_ff;
      if (cmd.emit && odd) begin
         if (count_ff == '0) begin
            row_in     = side_length >> 1;
            col_in     = side_length >> 1;
            heading_in = start_direction;
            len_in     = COORD_W'(1);
            step_in    = '0;
            idx_in     = 1'b0;
         end else begin
            case (heading_ff)
               HEAD_LEFT:  col_in = col_ff - COORD_W'(1);
               HEAD_UP:    row_in = row_ff - COORD_W'(1);
               HEAD_RIGHT: col_in = col_ff + COORD_W'(1);
               default:    row_in = row_ff + COORD_W'(1);
            endcase
            if (step_next == len_ff) begin
               step_in    = '0;
               heading_in = heading_ff + HEAD_W'(1);
               idx_in     = ~idx_ff;
               if (idx_ff) len_in = len_ff + COORD_W'(1);
            end else begin
               step_in = step_next;
            end
         end
         count_in = is_last ? '0 : count_inc;
      end
   end

   assign rd_addr = {row_in, col_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff     <= '0;
         col_ff     <= '0;
         len_ff     <= COORD_W'(1);
         step_ff    <= '0;
         idx_ff     <= 1'b0;
         heading_ff <= HEAD_LEFT;
         count_ff   <= '0;
      end else begin
         row_ff     <= row_in;
         col_ff     <= col_in;
         len_ff     <= len_in;
         step_ff    <= step_in;
         idx_ff     <= idx_in;
         heading_ff <= heading_in;
         count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_write) mem[{req_row, req_col}] <= req_value;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rdata_ff <= mem[rd_addr];
         last_ff  <= odd && is_last;
         err_ff   <= !odd;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         dout_ff     <= err_ff ? '0 : rdata_ff;
         last_out_ff <= last_ff;
         err_out_ff  <= err_ff;
      end
   end

   assign data_out = dout_ff;
   assign last     = last_out_ff;
   assign error    = err_out_ff;

`ifndef ASSERT_OFF
   a_start_centre: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && odd && count_ff == '0 |=>
         row_ff == ($past(side_length) >> 1) && col_ff == row_ff)
      else $error("traversal did not start at the centre");
   a_even_holds: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && !odd |=> $stable(count_ff) && $stable(row_ff) && $stable(col_ff))
      else $error("cursor moved on even side length");
`endif
endmodule

/* bench/center_out_spiral_matrix_scan_unit_tb.sv */
// ----------------------------------------------------------------------------
// center_out_spiral_matrix_scan_unit_tb
// Self-checking bench for the centre-out spiral scan unit. Loads and emits
// are sent over the request channel. Each emit is predicted from a local
// copy of the matrix, the cursor and the two registers. Responses are
// checked field by field in order. Runs cover directed corner cases, then
// random traffic under several sender idle and receiver stall mixes.
// ----------------------------------------------------------------------------
module center_out_spiral_matrix_scan_unit_tb;
   import csms_pkg::*;

   localparam int          CYCLE_LIMIT       = 500000;
   localparam int          ITEMS_PER_SETTING = 112;
   localparam int          SETTLE_CYCLES     = 4;

   typedef struct packed {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [COUNT_W-1:0] count;
      logic [COORD_W-1:0] leg_len;
      logic [COORD_W-1:0] leg_step;
      logic               leg_second;
      logic [HEAD_W-1:0]  heading;
   } spiral_pos_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] data;
      logic                         last;
      logic                         error;
   } scan_result_type;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   csms_req_if req_if ();
   csms_rsp_if rsp_if ();

   center_out_spiral_matrix_scan_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   logic signed [DATA_WIDTH-1:0] cell_mem     [MAX_SIDE][MAX_SIDE];
   bit                           cell_written [MAX_SIDE][MAX_SIDE];
   logic [COORD_W-1:0]           side_cfg  = 5'd1;
   logic [HEAD_W-1:0]            start_cfg = HEAD_LEFT;
   spiral_pos_type               scan_pos  = '{row: '0, col: '0, count: '0, leg_len: 5'd1,
                                               leg_step: '0, leg_second: 1'b0, heading: HEAD_LEFT};
   scan_result_type              expected_elements [$];
   int                           mismatches  = 0;
   int                           idle_pct    = 0;
   int                           stall_pct   = 0;
   int unsigned                  cycle_count = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   // next spiral position after one good emit from position p
   function automatic spiral_pos_type spiral_step(spiral_pos_type p);
      spiral_pos_type n;
      int unsigned area;
      n    = p;
      area = int'(side_cfg) * int'(side_cfg);
      if (p.count == '0) begin
         n.row        = side_cfg >> 1;
         n.col        = side_cfg >> 1;
         n.heading    = start_cfg;
         n.leg_len    = 5'd1;
         n.leg_step   = '0;
         n.leg_second = 1'b0;
      end else begin
         case (p.heading)
            HEAD_LEFT:  n.col = p.col - 1'b1;
            HEAD_UP:    n.row = p.row - 1'b1;
            HEAD_RIGHT: n.col = p.col + 1'b1;
            default:    n.row = p.row + 1'b1;
         endcase
         n.leg_step = p.leg_step + 1'b1;
         if (n.leg_step == p.leg_len) begin
            n.leg_step   = '0;
            n.heading    = p.heading + 1'b1;
            n.leg_second = ~p.leg_second;
            if (!n.leg_second) n.leg_len = p.leg_len + 1'b1;
         end
      end
      n.count = p.count + 1'b1;
      if (n.count >= area || n.count == '0) n.count = '0;
      return n;
   endfunction

   function automatic void predict_emit();
      spiral_pos_type  n;
      scan_result_type r;
      if (!side_cfg[0]) begin
         r = '{data: '0, last: 1'b0, error: 1'b1};
      end else begin
         n       = spiral_step(scan_pos);
         r.data  = cell_mem[n.row][n.col];
         r.last  = (n.count == '0);
         r.error = 1'b0;
         scan_pos = n;
      end
      expected_elements.push_back(r);
   endfunction

   task automatic send_item(input logic op, input logic [COORD_W-1:0] r,
                            input logic [COORD_W-1:0] c, input logic signed [DATA_WIDTH-1:0] v);
      while ($urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.operation <= op;
      req_if.row       <= r;
      req_if.col       <= c;
      req_if.value     <= v;
      do @(posedge clock); while (!req_if.ready);
      if (op == OP_LOAD) begin
         cell_mem[r][c]     = v;
         cell_written[r][c] = 1'b1;
      end else begin
         predict_emit();
      end
   endtask

   // for an odd side length, loads the next cell first if it has never been written
   task automatic emit_next();
      spiral_pos_type n;
      if (side_cfg[0]) begin
         n = spiral_step(scan_pos);
         if (!cell_written[n.row][n.col]) begin
            send_item(OP_LOAD, n.row, n.col, DATA_WIDTH'($urandom));
         end
      end
      send_item(OP_EMIT, COORD_W'($urandom), COORD_W'($urandom), DATA_WIDTH'($urandom));
   endtask

   task automatic settle();
      req_if.valid <= 1'b0;
      while (expected_elements.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [CSR_DATA_W-1:0] data);
      logic [CSR_DATA_W-1:0] held;
      held    = (idx == REG_SIDE_LENGTH) ? (data & 32'h1f) : (data & 32'h3);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (idx == REG_SIDE_LENGTH) side_cfg = held[COORD_W-1:0];
      else start_cfg = held[HEAD_W-1:0];
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== held) begin
         $display("%0t: register %0d read back expected %0d got %0d", $time, idx, held, prdata);
         mismatches++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin : response_check
      scan_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_elements.size() == 0) begin
            $display("%0t: unexpected transaction data_out %0d last %0b error %0b", $time,
                     rsp_if.data_out, rsp_if.last, rsp_if.error);
            mismatches++;
         end else begin
            want = expected_elements.pop_front();
            if (rsp_if.data_out !== want.data || rsp_if.last !== want.last ||
                rsp_if.error !== want.error) begin
               $display("%0t: expected data_out %0d last %0b error %0b, got %0d %0b %0b",
                        $time, want.data, want.last, want.error,
                        rsp_if.data_out, rsp_if.last, rsp_if.error);
               mismatches++;
            end
         end
      end
   end

   task automatic test_extreme_values();
      send_item(OP_LOAD, 5'd0, 5'd0, -16'sd32768);
      emit_next();
      send_item(OP_LOAD, 5'd31, 5'd31, 16'sd32767);
      send_item(OP_LOAD, 5'd31, 5'd0, -16'sd1);
      send_item(OP_LOAD, 5'd0, 5'd31, 16'sd1);
   endtask

   task automatic test_even_side();
      settle();
      write_reg(REG_SIDE_LENGTH, 32'd0);
      emit_next();
      settle();
      write_reg(REG_SIDE_LENGTH, 32'd30);
      emit_next();
   endtask

   task automatic test_full_square();
      settle();
      write_reg(REG_SIDE_LENGTH, 32'd3);
      write_reg(REG_START_DIRECTION, 32'(HEAD_RIGHT));
      repeat (9) emit_next();
   endtask

   // growing the side mid-scan walks the cursor off column 0 and wraps it
   task automatic test_resize_mid_scan();
      settle();
      write_reg(REG_START_DIRECTION, 32'(HEAD_LEFT));
      repeat (3) emit_next();
      settle();
      write_reg(REG_SIDE_LENGTH, 32'd5);
      repeat (7) emit_next();
   endtask

   task automatic test_random_traffic(input int sender_idle, input int receiver_stall,
                                      input int phase);
      logic [COORD_W-1:0] side;
      idle_pct  = sender_idle;
      stall_pct = receiver_stall;
      for (int k = 0; k < 4; k++) begin
         case (k)
            0:       side = 5'(2 * $urandom_range(1, 5) + 1);
            1:       side = phase[0] ? 5'd1 : 5'd31;
            2:       side = 5'($urandom_range(31));
            default: side = 5'(2 * $urandom_range(0, 3) + 1);
         endcase
         settle();
         write_reg(REG_SIDE_LENGTH, 32'(side));
         write_reg(REG_START_DIRECTION, 32'((phase + k) % 4));
         for (int i = 0; i < ITEMS_PER_SETTING; i++) begin
            if ($urandom_range(99) < 15) begin
               send_item(OP_LOAD, COORD_W'($urandom), COORD_W'($urandom),
                         DATA_WIDTH'($urandom));
            end else begin
               emit_next();
            end
         end
      end
   endtask

   initial begin
      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.operation <= OP_LOAD;
      req_if.row       <= '0;
      req_if.col       <= '0;
      req_if.value     <= '0;
      psel             <= 1'b0;
      penable          <= 1'b0;
      pwrite           <= 1'b0;
      paddr            <= '0;
      pwdata           <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_extreme_values();
      test_even_side();
      test_full_square();
      test_resize_mid_scan();
      test_random_traffic(0, 0, 0);
      test_random_traffic(67, 0, 1);
      test_random_traffic(0, 67, 2);
      test_random_traffic(32, 32, 3);

      settle();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/core/csms_pkg.sv
rtl/core/csms_req_if.sv
rtl/core/csms_rsp_if.sv
rtl/core/csms_ctrl.sv
rtl/core/csms_dpath.sv
rtl/core/center_out_spiral_matrix_scan_unit.sv
bench/center_out_spiral_matrix_scan_unit_tb.sv
